// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros for the rtl files
// depends on signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, off while reset is high
`define ASSERT_AT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
   `ASSERT_AT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/llcf_pkg.sv =====
// llcf_pkg: types, codes and keyword tables of the log line classify filter
// no dependencies; used by the channel interfaces and the top level
package llcf_pkg;

   // fixed widths of the channel fields
   localparam int CMD_W      = 2;
   localparam int BYTE_W     = 8;
   localparam int PIDX_W     = 6;
   localparam int LINE_NUM_W = 13;
   localparam int LEVEL_W    = 3;
   localparam int MASK_W     = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   // pattern store and its alignment shifter
   localparam int PAT_MAX = 63;
   localparam int SH_W    = $clog2(PAT_MAX);

   // input commands
   typedef enum logic [CMD_W-1:0] {
      CMD_TEXT    = 2'd0,
      CMD_FLUSH   = 2'd1,
      CMD_PATTERN = 2'd2,
      CMD_NONE    = 2'd3
   } command_type;

   // result levels
   typedef enum logic [LEVEL_W-1:0] {
      LVL_INFO  = 3'd0,
      LVL_OK    = 3'd1,
      LVL_WARN  = 3'd2,
      LVL_ERROR = 3'd3,
      LVL_DEBUG = 3'd4
   } level_type;

   // register indexes of the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL_MASK  = 1'd0,
      CSR_PATTERN_LEN = 1'd1
   } csr_index_type;

   // keyword flag bit positions
   localparam int FLG_ERROR = 0;
   localparam int FLG_WARN  = 1;
   localparam int FLG_DEBUG = 2;
   localparam int FLG_OK    = 3;
   localparam int FLG_W     = 4;

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

   // keywords in lower case, last character in the low byte
   localparam int KW_NUM = 8;
   localparam int KW_MAX = 8;
   localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_NUM] = '{
      64'("error"), 64'("fail"), 64'("fatal"), 64'("warn"),
      64'("debug"), 64'("[  ok  ]"), 64'("[ ok ]"), 64'(" ok ")
   };
   localparam int KW_LEN  [KW_NUM] = '{5, 4, 5, 4, 5, 8, 6, 4};
   localparam int KW_FLAG [KW_NUM] = '{
      FLG_ERROR, FLG_ERROR, FLG_ERROR, FLG_WARN, FLG_DEBUG, FLG_OK, FLG_OK, FLG_OK
   };

   // one result item
   typedef struct packed {
      logic [LINE_NUM_W-1:0] line_number;
      level_type             level;
      logic                  search_matched;
      logic                  kept;
   } result_type;

   // fold upper-case ascii letters to lower case
   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/llcf_if.sv =====
// llcf_if: valid/ready channel interfaces for requests, results and csr writes
// depends on llcf_pkg for the field widths
interface llcf_req_if;
   import llcf_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [BYTE_W-1:0] byte_value;
   logic [PIDX_W-1:0] pattern_index;
   modport source (output valid, command, byte_value, pattern_index, input ready);
   modport sink   (input valid, command, byte_value, pattern_index, output ready);
endinterface

interface llcf_rsp_if;
   import llcf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [LINE_NUM_W-1:0] line_number;
   logic [LEVEL_W-1:0]    level;
   logic                  search_matched;
   logic                  kept;
   modport source (output valid, line_number, level, search_matched, kept, input ready);
   modport sink   (input valid, line_number, level, search_matched, kept, output ready);
endinterface

interface llcf_csr_if;
   import llcf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/log_line_classify_filter_top.sv =====
// log_line_classify_filter_top: splits log text into lines, classifies and filters them
// depends on llcf_pkg, llcf_if.sv and assert_macros.svh
//
//   channel    dir   payload                                         role
//   req_chan   in    command, byte_value, pattern_index              text bytes, pattern writes
//   rsp_chan   out   line_number, level, search_matched, kept        one per non-empty line
//   csr_chan   in    index, data                                     level mask, pattern length
//
// one request per cycle while req_chan.ready is high; each is handled in the cycle it is
// accepted; a line result is registered in out_ff, or in skid_ff while out_ff is held
// the path is set by the 63-byte window shifter and its comparators
// rsp_chan has an output register plus one skid entry; req_chan.ready drops
// only while the skid entry is full; csr_chan is always ready
// reset (synchronous, active high) clears counters and flags and restores the csr defaults
`include "assert_macros.svh"

module log_line_classify_filter_top #(
   parameter int LINE_LIMIT = 8192,
   parameter int LINE_CHARS = 256
) (
   input  logic       clock,
   input  logic       reset,
   llcf_req_if.sink   req_chan,
   llcf_rsp_if.source rsp_chan,
   llcf_csr_if.sink   csr_chan
);
   import llcf_pkg::*;

   localparam int CNT_W = $clog2(LINE_LIMIT + 1);
   localparam int CHR_W = $clog2(LINE_CHARS + 1);

   // csr registers
   logic [MASK_W-1:0] mask_ff;
   logic [PIDX_W-1:0] plen_ff;

   // pattern store, folded, no reset
   logic [BYTE_W-1:0] pat_ff [PAT_MAX];

   // window of recent folded characters, index 0 newest
   logic [BYTE_W-1:0] win_ff [PAT_MAX];
   logic [BYTE_W-1:0] win_in [PAT_MAX];

   // line state
   logic [CHR_W-1:0] chars_ff, chars_in;
   logic [FLG_W-1:0] flags_ff, flags_in;
   logic             hit_ff, hit_in;
   logic [CNT_W-1:0] line_cnt_ff, line_cnt_in;

   // output register and skid entry
   result_type out_ff, out_in, skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic        req_fire, out_take;
   command_type cmd;
   logic        is_text, end_text, line_end, take_char, emit;
   logic [CHR_W-1:0]  chars_new;
   logic [FLG_W-1:0]  kw_flags;
   logic [PIDX_W-1:0] plen_eff;
   logic [SH_W-1:0]   shift_amt;
   logic [BYTE_W-1:0] algn [SH_W+1][PAT_MAX];
   logic              pat_all, pat_hit, kw_same;
   result_type        res;
   level_type         lvl;

   assign req_fire = req_chan.valid & req_chan.ready;
   assign out_take = out_valid_ff & rsp_chan.ready;
   assign req_chan.ready = ~skid_valid_ff;
   assign csr_chan.ready = 1'b1;

   // command decode
   always_comb begin
      cmd       = command_type'(req_chan.command);
      is_text   = 1'b0;
      end_text  = 1'b0;
      unique case (cmd)
         CMD_TEXT: begin
            is_text  = 1'b1;
            end_text = (req_chan.byte_value == '0);
         end
         CMD_FLUSH: begin
            end_text = 1'b1;
         end
         default: begin
            is_text  = 1'b0;
         end
      endcase
      line_end  = end_text | (is_text & (req_chan.byte_value == CHAR_CR ||
                                         req_chan.byte_value == CHAR_LF));
      take_char = is_text & ~line_end;
   end

   // shifted window and saturating character count
   always_comb begin
      win_in[0] = fold(req_chan.byte_value);
      for (int i = 1; i < PAT_MAX; i++) begin
         win_in[i] = win_ff[i-1];
      end
      chars_new = (chars_ff < CHR_W'(LINE_CHARS)) ? chars_ff + 1'b1 : chars_ff;
   end

   // keyword comparators on the fixed window taps
   always_comb begin
      kw_flags = '0;
      for (int k = 0; k < KW_NUM; k++) begin
         kw_same = (32'(chars_new) >= KW_LEN[k]);
         for (int i = 0; i < KW_MAX; i++) begin
            if (i < KW_LEN[k] && win_in[i] != KW_TEXT[k][8*i +: 8]) begin
               kw_same = 1'b0;
            end
         end
         if (kw_same) begin
            kw_flags[KW_FLAG[k]] = 1'b1;
         end
      end
   end

   // align the window to the pattern: algn[last][j] is the char matched by pattern[j]
   always_comb begin
      plen_eff  = (32'(plen_ff) > PAT_MAX) ? PIDX_W'(PAT_MAX) : plen_ff;
      shift_amt = SH_W'(PAT_MAX - 32'(plen_eff));
      for (int k = 0; k < PAT_MAX; k++) begin
         algn[0][k] = win_in[PAT_MAX-1-k];
      end
      for (int b = 0; b < SH_W; b++) begin
         for (int j = 0; j < PAT_MAX; j++) begin
            if (!shift_amt[b]) begin
               algn[b+1][j] = algn[b][j];
            end else if (j + (1 << b) < PAT_MAX) begin
               algn[b+1][j] = algn[b][j + (1 << b)];
            end else begin
               algn[b+1][j] = '0;
            end
         end
      end
      pat_all = 1'b1;
      for (int j = 0; j < PAT_MAX; j++) begin
         if (j < int'(plen_eff) && algn[SH_W][j] != pat_ff[j]) begin
            pat_all = 1'b0;
         end
      end
      pat_hit = (plen_eff != '0) && pat_all &&
                (32'(chars_new) >= 32'(plen_eff)) &&
                (32'(chars_new) <= LINE_CHARS - 1);
   end

   // line result from the flags gathered so far
   always_comb begin
      if (flags_ff[FLG_ERROR]) begin
         lvl = LVL_ERROR;
      end else if (flags_ff[FLG_WARN]) begin
         lvl = LVL_WARN;
      end else if (flags_ff[FLG_DEBUG]) begin
         lvl = LVL_DEBUG;
      end else if (flags_ff[FLG_OK]) begin
         lvl = LVL_OK;
      end else begin
         lvl = LVL_INFO;
      end
      res.line_number    = LINE_NUM_W'(line_cnt_ff);
      res.level          = lvl;
      res.search_matched = (plen_eff == '0) | hit_ff;
      res.kept           = mask_ff[lvl] & res.search_matched;
      emit = req_fire & line_end & (chars_ff != '0) & (line_cnt_ff < CNT_W'(LINE_LIMIT));
   end

   // line state next values
   always_comb begin
      chars_in    = chars_ff;
      flags_in    = flags_ff;
      hit_in      = hit_ff;
      line_cnt_in = line_cnt_ff;
      if (req_fire && line_end) begin
         chars_in = '0;
         flags_in = '0;
         hit_in   = 1'b0;
         if (end_text) begin
            line_cnt_in = '0;
         end else if (emit) begin
            line_cnt_in = line_cnt_ff + 1'b1;
         end
      end else if (req_fire && take_char) begin
         chars_in = chars_new;
         flags_in = flags_ff | kw_flags;
         hit_in   = hit_ff | pat_hit;
      end
   end

   // output register and skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (emit) begin
         if (!out_valid_ff || out_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.line_number    = out_ff.line_number;
   assign rsp_chan.level          = out_ff.level;
   assign rsp_chan.search_matched = out_ff.search_matched;
   assign rsp_chan.kept           = out_ff.kept;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= '1;
         plen_ff       <= '0;
         chars_ff      <= '0;
         flags_ff      <= '0;
         hit_ff        <= 1'b0;
         line_cnt_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_index_type'(csr_chan.index))
               CSR_LEVEL_MASK:  mask_ff <= csr_chan.data[MASK_W-1:0];
               CSR_PATTERN_LEN: plen_ff <= csr_chan.data[PIDX_W-1:0];
               default:         plen_ff <= plen_ff;
            endcase
         end
         chars_ff      <= chars_in;
         flags_ff      <= flags_in;
         hit_ff        <= hit_in;
         line_cnt_ff   <= line_cnt_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (req_fire && take_char) begin
         win_ff <= win_in;
      end
      if (req_fire && cmd == CMD_PATTERN && 32'(req_chan.pattern_index) < PAT_MAX) begin
         pat_ff[req_chan.pattern_index] <= fold(req_chan.byte_value);
      end
   end

   // checks
   `ASSERT_IMPLY(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid entry without output")
   `ASSERT_AT_CLK(a_line_cnt_bound, line_cnt_ff <= CNT_W'(LINE_LIMIT), "line count over limit")
   `ASSERT_AT_CLK(a_chars_bound, chars_ff <= CHR_W'(LINE_CHARS), "line length over bound")
   `ASSERT_IMPLY(a_kept_needs_match, out_valid_ff && out_ff.kept, out_ff.search_matched, "kept without match")
   `ASSERT_AT_CLK(a_end_text_clears, (req_fire && end_text) |=> (line_cnt_ff == '0 && chars_ff == '0), "end of text did not clear")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for log_line_classify_filter_top; streams log lines, pattern
// writes and csr writes, predicts every line result and checks it field by field
// depends on llcf_pkg, llcf_if.sv and log_line_classify_filter_top
module tb;
   import llcf_pkg::*;

   localparam int LINE_LIMIT      = 8192;
   localparam int LINE_CHARS      = 256;
   localparam int PATTERN_DEPTH   = 63;
   localparam int TAIL_CYCLES     = 8;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int PHASES          = 5;
   localparam logic [BYTE_W-1:0] END_OF_TEXT = 8'h00;

   typedef struct packed {
      command_type          command;
      logic [BYTE_W-1:0]    byte_value;
      logic [PIDX_W-1:0]    pattern_index;
   } request_type;

   logic clock;
   logic reset;

   llcf_req_if req_chan ();
   llcf_rsp_if rsp_chan ();
   llcf_csr_if csr_chan ();

   log_line_classify_filter_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // keywords as the classifier sees them, after case folding
   string keyword_text [8] = '{"error", "fail", "fatal", "warn", "debug",
                               "[  ok  ]", "[ ok ]", " ok "};
   int    keyword_flag [8] = '{FLG_ERROR, FLG_ERROR, FLG_ERROR, FLG_WARN, FLG_DEBUG,
                               FLG_OK, FLG_OK, FLG_OK};

   // predicted state of the filter
   logic [BYTE_W-1:0]     pattern_copy [PATTERN_DEPTH] = '{default: '0};
   logic [BYTE_W-1:0]     window [PATTERN_DEPTH] = '{default: '0};   // index 0 is newest
   int unsigned           line_chars = 0;
   int unsigned           lines_emitted = 0;
   logic [FLG_W-1:0]      line_flags = '0;
   logic                  line_hit = 1'b0;
   logic [MASK_W-1:0]     level_mask;
   logic [CSR_DATA_W-1:0] pattern_len;

   result_type  expected_lines [$];
   request_type pending_requests [$];

   // pattern the generator plants into lines
   logic [BYTE_W-1:0] planted_pattern [PATTERN_DEPTH];
   int                planted_len;

   int          send_idle_pct;
   int          stall_pct;
   int          phase_items;
   int          mismatches = 0;
   bit          req_fire = 1'b0;
   int unsigned cycle_count = 0;

   function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
      if (c >= "A" && c <= "Z") begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // close the current line, emit a result if it is non-empty and under the limit
   function automatic void finish_line();
      level_type  lvl;
      result_type line_result;
      if (line_chars > 0 && lines_emitted < LINE_LIMIT) begin
         if (line_flags[FLG_ERROR]) lvl = LVL_ERROR;
         else if (line_flags[FLG_WARN]) lvl = LVL_WARN;
         else if (line_flags[FLG_DEBUG]) lvl = LVL_DEBUG;
         else if (line_flags[FLG_OK]) lvl = LVL_OK;
         else lvl = LVL_INFO;
         line_result.line_number    = lines_emitted[LINE_NUM_W-1:0];
         line_result.level          = lvl;
         line_result.search_matched = (pattern_len == 0) || line_hit;
         line_result.kept           = level_mask[int'(lvl)] && line_result.search_matched;
         expected_lines.push_back(line_result);
         lines_emitted++;
      end
      line_chars = 0;
      line_flags = '0;
      line_hit   = 1'b0;
   endfunction

   // shift one character into the window, update keyword flags and search hit
   function automatic void take_char(input logic [BYTE_W-1:0] c);
      int len;
      bit same;
      for (int i = PATTERN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = to_lower(c);
      if (line_chars < LINE_CHARS) line_chars++;
      for (int k = 0; k < 8; k++) begin
         len  = keyword_text[k].len();
         same = (line_chars >= len);
         for (int j = 0; j < len; j++) begin
            if (window[len-1-j] != keyword_text[k][j]) same = 0;
         end
         if (same) line_flags[keyword_flag[k]] = 1'b1;
      end
      // only matches that end within the first LINE_CHARS-1 characters count
      if (pattern_len > 0 && line_chars >= pattern_len && line_chars <= LINE_CHARS - 1) begin
         same = 1;
         for (int j = 0; j < pattern_len; j++) begin
            if (window[pattern_len-1-j] != to_lower(pattern_copy[j])) same = 0;
         end
         if (same) line_hit = 1'b1;
      end
   endfunction

   function automatic void classify_request(input request_type item);
      case (item.command)
         CMD_PATTERN: begin
            if (item.pattern_index < PATTERN_DEPTH) pattern_copy[item.pattern_index] = item.byte_value;
         end
         CMD_FLUSH: begin
            finish_line();
            lines_emitted = 0;
         end
         CMD_TEXT: begin
            if (item.byte_value == END_OF_TEXT) begin
               finish_line();
               lines_emitted = 0;
            end else if (item.byte_value == CHAR_CR || item.byte_value == CHAR_LF) begin
               finish_line();
            end else begin
               take_char(item.byte_value);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus generation: every push helper appends to the pending queue
   // ------------------------------------------------------------------
   function automatic void push_request(input command_type cmd, input logic [BYTE_W-1:0] b,
                                        input logic [PIDX_W-1:0] idx);
      request_type item;
      item.command       = cmd;
      item.byte_value    = b;
      item.pattern_index = idx;
      pending_requests.push_back(item);
      phase_items++;
   endfunction

   function automatic void push_byte(input logic [BYTE_W-1:0] b);
      push_request(CMD_TEXT, b, PIDX_W'($urandom_range(0, 63)));
   endfunction

   // any text byte that neither ends a line nor ends the text
   function automatic logic [BYTE_W-1:0] body_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(1, 255));
      while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   function automatic logic [BYTE_W-1:0] mix_case(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] low;
      low = to_lower(c);
      if (low >= "a" && low <= "z" && $urandom_range(0, 1)) begin
         return low - 8'h20;
      end
      return low;
   endfunction

   function automatic void push_text(input string s, input bit vary);
      for (int j = 0; j < s.len(); j++) begin
         push_byte(vary ? mix_case(s[j]) : s[j]);
      end
   endfunction

   function automatic void push_pattern_prefix(input int count);
      for (int j = 0; j < count; j++) push_byte(mix_case(planted_pattern[j]));
   endfunction

   function automatic void push_keyword();
      int k;
      k = $urandom_range(0, 8);
      if (k == 8) push_text("info", 1);
      else push_text(keyword_text[k], 1);
   endfunction

   function automatic void push_word();
      int n;
      n = $urandom_range(1, 8);
      for (int j = 0; j < n; j++) push_byte(mix_case(BYTE_W'("a" + $urandom_range(0, 25))));
   endfunction

   // occasional noise: unused command or a pattern write that keeps matches alive
   function automatic void push_noise();
      int idx;
      if ($urandom_range(0, 1)) begin
         push_request(CMD_NONE, BYTE_W'($urandom), PIDX_W'($urandom));
      end else begin
         idx = $urandom_range(0, 63);
         if (idx < PATTERN_DEPTH) begin
            if ($urandom_range(0, 3) == 0 && idx >= planted_len) planted_pattern[idx] = body_byte();
            push_request(CMD_PATTERN, mix_case(planted_pattern[idx]), PIDX_W'(idx));
         end else begin
            push_request(CMD_PATTERN, BYTE_W'($urandom), PIDX_W'(idx));
         end
      end
   endfunction

   function automatic void push_line();
      int shape;
      int count;
      if ($urandom_range(0, 99) < 5) push_noise();
      shape = $urandom_range(0, 99);
      if (shape < 4) begin
         // long line, the planted pattern ends right at or just past the search cutoff
         if (planted_len > 0) count = LINE_CHARS - 1 - planted_len + $urandom_range(0, 1);
         else count = $urandom_range(250, 300);
         for (int j = 0; j < count; j++) begin
            push_byte(mix_case(BYTE_W'("a" + $urandom_range(0, 25))));
         end
         push_pattern_prefix(planted_len);
         if ($urandom_range(0, 1)) push_keyword();
      end else begin
         count = $urandom_range(0, 5);
         for (int f = 0; f < count; f++) begin
            case ($urandom_range(0, 6))
               0, 1: push_keyword();
               2:    push_pattern_prefix(planted_len);
               3:    push_pattern_prefix(planted_len > 0 ? $urandom_range(0, planted_len - 1) : 0);
               4:    push_word();
               5:    push_byte(" ");
               default: begin
                  repeat ($urandom_range(1, 3)) push_byte(body_byte());
               end
            endcase
         end
      end
      // line end, including empty lines and end of text
      shape = $urandom_range(0, 99);
      if (shape < 50) push_byte(CHAR_LF);
      else if (shape < 70) push_byte(CHAR_CR);
      else if (shape < 85) begin
         push_byte(CHAR_CR);
         push_byte(CHAR_LF);
      end else if (shape < 90) begin
         push_byte(CHAR_LF);
         push_byte(CHAR_LF);
      end else if (shape < 95) push_byte(END_OF_TEXT);
      else push_request(CMD_FLUSH, BYTE_W'($urandom), PIDX_W'($urandom));
   endfunction

   // ------------------------------------------------------------------
   // clock, watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // monitor: predicts on every request transfer, checks every result transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      request_type seen;
      result_type  want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_chan.valid && req_chan.ready;
         if (req_fire) begin
            seen.command       = command_type'(req_chan.command);
            seen.byte_value    = req_chan.byte_value;
            seen.pattern_index = req_chan.pattern_index;
            classify_request(seen);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_lines.size() == 0) begin
               $error("result transfer with no line pending: line_number %0d",
                      rsp_chan.line_number);
               mismatches++;
            end else begin
               want = expected_lines.pop_front();
               compare_field("line_number", 16'(want.line_number), 16'(rsp_chan.line_number));
               compare_field("level", 16'(want.level), 16'(rsp_chan.level));
               compare_field("search_matched", 16'(want.search_matched),
                             16'(rsp_chan.search_matched));
               compare_field("kept", 16'(want.kept), 16'(rsp_chan.kept));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // driver: presents pending requests, holds each until its transfer
   // ------------------------------------------------------------------
   always @(negedge clock) begin : driver
      if (reset) begin
         req_chan.valid         <= 1'b0;
         req_chan.command       <= CMD_TEXT;
         req_chan.byte_value    <= '0;
         req_chan.pattern_index <= '0;
      end else if (!req_chan.valid || req_fire) begin
         if (req_chan.valid) pending_requests.delete(0);
         if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_chan.valid         <= 1'b1;
            req_chan.command       <= pending_requests[0].command;
            req_chan.byte_value    <= pending_requests[0].byte_value;
            req_chan.pattern_index <= pending_requests[0].pattern_index;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver side stalls
   always @(negedge clock) begin : result_sink
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // ------------------------------------------------------------------
   // sequencing
   // ------------------------------------------------------------------
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      if (idx == CSR_LEVEL_MASK) level_mask = value[MASK_W-1:0];
      else pattern_len = value;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_requests.size() > 0 || req_chan.valid || expected_lines.size() > 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [MASK_W-1:0]     phase_mask;
      logic [CSR_DATA_W-1:0] phase_len;
      reset                  = 1'b1;
      csr_chan.valid         = 1'b0;
      csr_chan.index         = CSR_LEVEL_MASK;
      csr_chan.data          = '0;
      level_mask    = '1;
      pattern_len   = '0;
      planted_len   = 0;
      send_idle_pct = 0;
      stall_pct     = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset csr values, ignored commands, line ends, case folding, end of text
      push_request(CMD_PATTERN, 8'hA5, 6'd63);
      push_request(CMD_NONE, 8'hFF, 6'h3F);
      push_text("Warn", 0);
      push_byte(CHAR_LF);
      push_text("dEBUG", 0);
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      push_text(" OK ", 0);
      push_byte(CHAR_CR);
      push_byte(8'hFF);
      push_byte("Z");
      push_byte("@");
      push_request(CMD_FLUSH, 8'h00, 6'h00);
      push_byte(END_OF_TEXT);

      // fill the whole pattern store so no entry is ever read unwritten
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
         planted_pattern[i] = body_byte();
         push_request(CMD_PATTERN, planted_pattern[i], PIDX_W'(i));
      end
      wait_idle();

      // random phases, each with its own csr setting and idling pattern
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin phase_mask = 5'h1F; phase_len = 6'd3;  send_idle_pct = 0;  stall_pct = 0;  end
            1: begin phase_mask = 5'h00; phase_len = 6'd1;  send_idle_pct = 85; stall_pct = 0;  end
            2: begin phase_mask = 5'h0A; phase_len = 6'd63; send_idle_pct = 0;  stall_pct = 85; end
            3: begin
               phase_mask    = MASK_W'($urandom);
               phase_len     = CSR_DATA_W'($urandom_range(1, 12));
               send_idle_pct = 33;
               stall_pct     = 33;
            end
            default: begin
               phase_mask = 5'h15; phase_len = 6'd0; send_idle_pct = 0; stall_pct = 0;
            end
         endcase
         write_csr(CSR_LEVEL_MASK, {1'($urandom), phase_mask});
         write_csr(CSR_PATTERN_LEN, phase_len);
         phase_items = 0;
         planted_len = int'(phase_len);
         for (int j = 0; j < planted_len; j++) begin
            planted_pattern[j] = $urandom_range(0, 3)
                                 ? mix_case(BYTE_W'("a" + $urandom_range(0, 5)))
                                 : body_byte();
            push_request(CMD_PATTERN, planted_pattern[j], PIDX_W'(j));
         end
         while (phase_items < ITEMS_PER_PHASE) push_line();
         push_request(CMD_FLUSH, 8'h00, 6'h00);
         wait_idle();
      end

      // every level enabled, then end of text, a closing line and a flush
      write_csr(CSR_LEVEL_MASK, 6'h1F);
      send_idle_pct = 0;
      stall_pct     = 0;
      planted_len   = 0;
      push_byte(END_OF_TEXT);
      push_text("fail ok", 1);
      push_request(CMD_FLUSH, 8'h00, 6'h00);
      wait_idle();

      if (mismatches == 0 && expected_lines.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
